@@ src/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awp assertion failed");

// next-cycle implication, disabled in reset
`define AWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awp assertion failed");

`endif

@@ src/awp_pkg.sv @@
// shared constants, item and result types of the 28x28 to 8x8 area pool
// no dependencies
package awp_pkg;

    localparam int PIXEL_W           = 8;
    localparam int AVG_W             = 16;
    localparam int GRID_W            = 3;
    localparam int RUN_Q_W           = 3;
    localparam int RUN_M_W           = 2;
    localparam int LANES             = 16;
    localparam int LANE_W            = 4;
    localparam int CELL_WEIGHT       = 49;
    localparam int WEIGHT_W          = 6;
    localparam int REM_W             = 6;
    localparam int MID_DEPTH         = 4;
    localparam int OUT_DEPTH         = 8;
    localparam int DEF_PIXEL_BITS    = 8;
    localparam int DEF_FRACTION_BITS = 8;

    localparam logic [RUN_Q_W-1:0] Q_HALF    = 3'd3;
    localparam logic [RUN_Q_W-1:0] Q_LAST    = 3'd6;
    localparam logic [RUN_M_W-1:0] M_LAST    = 2'd3;
    localparam logic [GRID_W-1:0]  GRID_LAST = 3'd7;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
        logic               row_lo;
        logic               row_hi;
        logic               row_half;
        logic               col_lo;
        logic               col_hi;
        logic               col_half;
        logic [RUN_M_W-1:0] col_m;
        logic               done;
        logic [GRID_W-1:0]  done_row;
        logic [GRID_W-1:0]  done_col;
    } awp_item_t;

    typedef struct packed {
        logic [AVG_W-1:0]  average;
        logic [GRID_W-1:0] row;
        logic [GRID_W-1:0] col;
        logic              last;
    } awp_result_t;

endpackage

@@ src/area_weighted_pool_28_to_8.sv @@
// 28x28 to 8x8 area-weighted pool, one pixel word per cycle unless full
// cells go via mid queue, emit reg, divide, fraction reg, divide, out queue
// throughput: one pixel per cycle unless stalled; at most one result per pixel
// the rate is set by the 16 band accumulators, all updated on each pop
// reset: position counters and band sums cleared, both queues empty
// depends on awp_pkg, awp_front, awp_fifo, awp_back
module area_weighted_pool_28_to_8
    import awp_pkg::*;
#(
    parameter int PIXEL_BITS    = DEF_PIXEL_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [PIXEL_W-1:0] pixel,
    input  logic               frame_start,
    output logic               empty,
    input  logic               pop,
    output logic [AVG_W-1:0]   average,
    output logic [GRID_W-1:0]  out_row,
    output logic [GRID_W-1:0]  out_col,
    output logic               frame_last
);
    localparam int ITEM_W = $bits(awp_item_t);
    localparam int RES_W  = $bits(awp_result_t);
    localparam int OC_W   = $clog2(OUT_DEPTH + 1);

    logic                        mid_push, mid_full, mid_pop, mid_empty;
    awp_item_t                   front_item;
    logic [ITEM_W-1:0]           mid_data;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic                        res_push, res_full;
    awp_result_t                 res_in, res_out;
    logic [RES_W-1:0]            res_bits;
    logic [OC_W-1:0]             out_count;

    awp_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pixel       (pixel),
        .frame_start (frame_start),
        .q_full      (mid_full),
        .q_push      (mid_push),
        .q_item      (front_item)
    );

    assign full = mid_full;

    awp_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_item),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_data),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    awp_back #(
        .PIXEL_BITS    (PIXEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (mid_empty || (mid_count == '0)),
        .q_item    (awp_item_t'(mid_data)),
        .q_pop     (mid_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    awp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push && !res_full),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty),
        .count   (out_count)
    );

    assign res_out    = awp_result_t'(res_bits);
    assign average    = res_out.average;
    assign out_row    = res_out.row;
    assign out_col    = res_out.col;
    assign frame_last = res_out.last;

endmodule

@@ src/awp_fifo.sv @@
// small register queue with show-ahead read and fill count
// depends on nothing
module awp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    output logic                       full,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/awp_div49.sv @@
// two-stage divide by the cell weight: reciprocal multiply, then one correction
// depends on awp_pkg
module awp_div49
    import awp_pkg::*;
#(
    parameter int XW = 16,
    parameter int TW = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [XW-1:0]    in_x,
    input  logic [TW-1:0]    in_tag,
    output logic             out_valid,
    output logic [XW-1:0]    out_q,
    output logic [REM_W-1:0] out_r,
    output logic [TW-1:0]    out_tag,
    output logic [1:0]       stage_valid
);
    localparam int    K     = XW + 6;
    localparam int    M_W   = K - 5;
    localparam int    P_W   = XW + M_W;
    localparam int    R7_W  = REM_W + 1;
    localparam longint RECIP_L = (longint'(1) << K) / CELL_WEIGHT;
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

    logic             a_valid_reg;
    logic [P_W-1:0]   a_prod_reg;
    logic [XW-1:0]    a_x_reg;
    logic [TW-1:0]    a_tag_reg;
    logic             b_valid_reg;
    logic [XW-1:0]    b_q_reg, b_q_next;
    logic [REM_W-1:0] b_r_reg, b_r_next;
    logic [TW-1:0]    b_tag_reg;
    logic [XW-1:0]    q_est;
    logic [XW-1:0]    diff;
    logic [R7_W-1:0]  r_raw;
    logic             fix;

    always_comb
    begin
        q_est    = XW'(a_prod_reg >> K);
        diff     = a_x_reg - XW'(q_est * XW'(CELL_WEIGHT));
        r_raw    = R7_W'(diff);
        fix      = (r_raw >= R7_W'(CELL_WEIGHT));
        b_q_next = q_est + XW'(fix);
        b_r_next = REM_W'(fix ? r_raw - R7_W'(CELL_WEIGHT) : r_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_prod_reg <= P_W'(in_x) * P_W'(RECIP);
        a_x_reg    <= in_x;
        a_tag_reg  <= in_tag;
        b_q_reg    <= b_q_next;
        b_r_reg    <= b_r_next;
        b_tag_reg  <= a_tag_reg;
    end

    assign out_valid   = b_valid_reg;
    assign out_q       = b_q_reg;
    assign out_r       = b_r_reg;
    assign out_tag     = b_tag_reg;
    assign stage_valid = {a_valid_reg, b_valid_reg};

endmodule

@@ src/awp_front.sv @@
// front end: accepts pixels, tracks raster position, classifies each pixel
// depends on awp_pkg
module awp_front
    import awp_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [PIXEL_W-1:0] pixel,
    input  logic               frame_start,
    input  logic               q_full,
    output logic               q_push,
    output awp_item_t          q_item
);
    localparam int KEEP = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
    localparam logic [PIXEL_W-1:0] PIX_MASK = PIXEL_W'((1 << KEEP) - 1);

    logic [RUN_Q_W-1:0] row_q_reg, row_q_next, col_q_reg, col_q_next;
    logic [RUN_M_W-1:0] row_m_reg, row_m_next, col_m_reg, col_m_next;
    logic [RUN_Q_W-1:0] row_q, col_q;
    logic [RUN_M_W-1:0] row_m, col_m;
    logic               accept, col_wrap, line_end, row_wrap, row_done, col_done;

    assign accept = push && !q_full;
    assign q_push = accept;

    always_comb
    begin
        row_q = frame_start ? '0 : row_q_reg;
        row_m = frame_start ? '0 : row_m_reg;
        col_q = frame_start ? '0 : col_q_reg;
        col_m = frame_start ? '0 : col_m_reg;

        col_wrap = (col_q == Q_LAST);
        line_end = col_wrap && (col_m == M_LAST);
        row_wrap = (row_q == Q_LAST);

        col_q_next = col_wrap ? '0 : col_q + 1'b1;
        col_m_next = col_wrap ? ((col_m == M_LAST) ? '0 : col_m + 1'b1) : col_m;
        row_q_next = row_q;
        row_m_next = row_m;
        if (line_end)
        begin
            row_q_next = row_wrap ? '0 : row_q + 1'b1;
            row_m_next = row_wrap ? ((row_m == M_LAST) ? '0 : row_m + 1'b1) : row_m;
        end

        row_done = (row_q == Q_HALF) || (row_q == Q_LAST);
        col_done = (col_q == Q_HALF) || (col_q == Q_LAST);

        q_item.pixel       = pixel & PIX_MASK;
        q_item.frame_start = frame_start;
        q_item.row_lo      = (row_q <= Q_HALF);
        q_item.row_hi      = (row_q >= Q_HALF);
        q_item.row_half    = (row_q == Q_HALF);
        q_item.col_lo      = (col_q <= Q_HALF);
        q_item.col_hi      = (col_q >= Q_HALF);
        q_item.col_half    = (col_q == Q_HALF);
        q_item.col_m       = col_m;
        q_item.done        = row_done && col_done;
        q_item.done_row    = {row_m, row_q == Q_LAST};
        q_item.done_col    = {col_m, col_q == Q_LAST};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_q_reg <= '0;
            row_m_reg <= '0;
            col_q_reg <= '0;
            col_m_reg <= '0;
        end
        else if (accept)
        begin
            row_q_reg <= row_q_next;
            row_m_reg <= row_m_next;
            col_q_reg <= col_q_next;
            col_m_reg <= col_m_next;
        end
    end

endmodule

@@ src/awp_back.sv @@
// back end: band accumulators, cell emission and the divide-by-49 pipeline
// depends on awp_pkg, awp_div49
module awp_back
    import awp_pkg::*;
#(
    parameter int PIXEL_BITS    = DEF_PIXEL_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  awp_item_t                      q_item,
    output logic                           q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output awp_result_t                    res_data
);
    localparam int SUM_W = PIXEL_BITS + WEIGHT_W;
    localparam int T_W   = FRACTION_BITS + REM_W + 1;
    localparam int XW    = (SUM_W > T_W) ? SUM_W : T_W;
    localparam int AW    = XW + FRACTION_BITS;
    localparam int OC_W  = $clog2(OUT_DEPTH + 1);
    localparam int CR_W  = OC_W + 1;
    localparam int TAG_W = 2 * GRID_W;
    localparam int NSTG  = 6;
    localparam int RND   = CELL_WEIGHT / 2;

    logic [SUM_W-1:0]  sum_reg [LANES];
    logic [SUM_W-1:0]  sum_next [LANES];
    logic [SUM_W-1:0]  lane_next [LANES];
    logic [SUM_W-1:0]  add;
    logic [1:0]        shift;
    logic [LANE_W-1:0] emit_idx;
    logic              emit, credit_ok;
    logic [CR_W-1:0]   inflight;
    logic [NSTG-1:0]   stg_valid;

    logic              e_valid_reg;
    logic [SUM_W-1:0]  e_sum_reg;
    logic [TAG_W-1:0]  e_tag_reg;

    logic              d1_valid;
    logic [XW-1:0]     d1_q;
    logic [REM_W-1:0]  d1_r;
    logic [TAG_W-1:0]  d1_tag;
    logic [1:0]        d1_stg;

    logic              c_valid_reg;
    logic [XW-1:0]     c_t_reg;
    logic [XW+TAG_W-1:0] c_tag_reg;

    logic              d2_valid;
    logic [XW-1:0]     d2_q;
    logic [REM_W-1:0]  d2_r;
    logic [XW+TAG_W-1:0] d2_tag;
    logic [1:0]        d2_stg;

    logic [XW-1:0]     d2_a;
    logic [GRID_W-1:0] d2_row, d2_col;
    logic [AW-1:0]     wide;

    assign shift = {1'b0, ~q_item.row_half} + {1'b0, ~q_item.col_half};
    assign add   = SUM_W'(q_item.pixel) << shift;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        localparam logic [LANE_W-1:0] LID = LANE_W'(g);
        logic hit_row, hit_col;
        always_comb
        begin
            hit_row = LID[LANE_W-1] ? q_item.row_hi : q_item.row_lo;
            hit_col = (q_item.col_lo && (LID[GRID_W-1:0] == {q_item.col_m, 1'b0}))
                   || (q_item.col_hi && (LID[GRID_W-1:0] == {q_item.col_m, 1'b1}));
            lane_next[g] = (q_item.frame_start ? '0 : sum_reg[g])
                         + ((hit_row && hit_col) ? add : '0);
            sum_next[g]  = (emit && (emit_idx == LID)) ? '0 : lane_next[g];
        end
    end

    assign stg_valid = {e_valid_reg, d1_stg, c_valid_reg, d2_stg};

    always_comb
    begin
        inflight = CR_W'(out_count);
        for (int i = 0; i < NSTG; i++)
        begin
            inflight = inflight + CR_W'(stg_valid[i]);
        end
    end

    assign credit_ok = (inflight < CR_W'(OUT_DEPTH));
    assign q_pop     = !q_empty && (!q_item.done || credit_ok);
    assign emit      = q_pop && q_item.done;
    assign emit_idx  = {q_item.done_row[0], q_item.done_col};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= '0;
            end
            e_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    sum_reg[i] <= sum_next[i];
                end
            end
            e_valid_reg <= emit;
            c_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        e_sum_reg <= lane_next[emit_idx];
        e_tag_reg <= {q_item.done_row, q_item.done_col};
        c_t_reg   <= (XW'(d1_r) << FRACTION_BITS) + XW'(RND);
        c_tag_reg <= {d1_q, d1_tag};
    end

    awp_div49 #(
        .XW (XW),
        .TW (TAG_W)
    ) u_div_int (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (e_valid_reg),
        .in_x        (XW'(e_sum_reg)),
        .in_tag      (e_tag_reg),
        .out_valid   (d1_valid),
        .out_q       (d1_q),
        .out_r       (d1_r),
        .out_tag     (d1_tag),
        .stage_valid (d1_stg)
    );

    awp_div49 #(
        .XW (XW),
        .TW (XW + TAG_W)
    ) u_div_frac (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (c_valid_reg),
        .in_x        (c_t_reg),
        .in_tag      (c_tag_reg),
        .out_valid   (d2_valid),
        .out_q       (d2_q),
        .out_r       (d2_r),
        .out_tag     (d2_tag),
        .stage_valid (d2_stg)
    );

    always_comb
    begin
        {d2_a, d2_row, d2_col} = d2_tag;
        wide = (AW'(d2_a) << FRACTION_BITS) + AW'(d2_q);
        res_data.average = AVG_W'(wide);
        res_data.row     = d2_row;
        res_data.col     = d2_col;
        res_data.last    = (d2_row == GRID_LAST) && (d2_col == GRID_LAST) && (d2_r == d2_r);
    end

    assign res_push = d2_valid;

endmodule

@@ src/awp_checker.sv @@
// port-level checks on the area pool's result queue, bound to the top level
// depends on awp_pkg, assert_macros.svh, area_weighted_pool_28_to_8
`include "assert_macros.svh"

module awp_checker
    import awp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic [PIXEL_W-1:0] pixel,
    input logic               frame_start,
    input logic               empty,
    input logic               pop,
    input logic [AVG_W-1:0]   average,
    input logic [GRID_W-1:0]  out_row,
    input logic [GRID_W-1:0]  out_col,
    input logic               frame_last
);
    logic in_word;

    assign in_word = push && !full && (frame_start || !frame_start) && (pixel == pixel);

    `AWP_ASSERT_IMP(a_last_cell, clk, rst_n, !empty && frame_last, out_row == GRID_LAST && out_col == GRID_LAST)
    `AWP_ASSERT_IMP(a_avg_range, clk, rst_n, !empty || in_word, empty || average <= 16'hFF00)
    `AWP_ASSERT_NXT(a_hold_word, clk, rst_n, !empty && !pop, !empty)
    `AWP_ASSERT_NXT(a_hold_data, clk, rst_n, !empty && !pop, $stable(average) && $stable(out_row) && $stable(out_col) && $stable(frame_last))

endmodule

bind area_weighted_pool_28_to_8 awp_checker u_awp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .pixel       (pixel),
    .frame_start (frame_start),
    .empty       (empty),
    .pop         (pop),
    .average     (average),
    .out_row     (out_row),
    .out_col     (out_col),
    .frame_last  (frame_last)
);

@@ tb/area_weighted_pool_28_to_8_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the 28x28 to 8x8 area-weighted pool: raster pixel words in,
// cell average words out, each compared with a local prediction of the cell sums
// depends on awp_pkg and area_weighted_pool_28_to_8
module area_weighted_pool_28_to_8_test;
    import awp_pkg::*;

    localparam int IMG_SIDE   = 28;
    localparam int IMG_PIXELS = IMG_SIDE * IMG_SIDE;
    localparam int RUN        = 7;
    localparam int TAIL_WORDS = 200;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               start;
    } pixel_word_t;

    typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_EXTREME} fill_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               push        = 1'b0;
    logic [PIXEL_W-1:0] pixel       = '0;
    logic               frame_start = 1'b0;
    logic               pop         = 1'b0;
    logic               full;
    logic               empty;
    logic [AVG_W-1:0]   average;
    logic [GRID_W-1:0]  out_row;
    logic [GRID_W-1:0]  out_col;
    logic               frame_last;

    pixel_word_t pixel_words[$];
    awp_result_t cell_words[$];
    logic [4:0]  next_row;
    logic [4:0]  next_col;
    logic [19:0] band_sum [LANES];
    int          errors         = 0;
    int          send_idle      = 0;
    int          recv_idle      = 0;
    int          total_words    = 0;
    int          accepted_words = 0;

    area_weighted_pool_28_to_8 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .frame_start(frame_start),
        .empty      (empty),
        .pop        (pop),
        .average    (average),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

    always #10 clk = ~clk;

    // cells touched along one axis, weights in halves
    function automatic int axis_split(input logic [4:0] p, output logic [1:0][2:0] slot,
                                      output logic [1:0][1:0] wt);
        int m;
        int q;
        m = p / RUN;
        q = p % RUN;
        slot = '0;
        wt = '0;
        if (q < 3)
        begin
            slot[0] = 3'(2 * m);
            wt[0] = 2'd2;
            return 1;
        end
        if (q == 3)
        begin
            slot[0] = 3'(2 * m);
            wt[0] = 2'd1;
            slot[1] = 3'(2 * m + 1);
            wt[1] = 2'd1;
            return 2;
        end
        slot[0] = 3'(2 * m + 1);
        wt[0] = 2'd2;
        return 1;
    endfunction

    function automatic bit axis_done(input logic [4:0] p, output logic [2:0] slot);
        int m;
        int q;
        m = p / RUN;
        q = p % RUN;
        slot = 3'(2 * m + ((q == 6) ? 1 : 0));
        return (q == 3) || (q == 6);
    endfunction

    function automatic bit predict_cell(input logic [PIXEL_W-1:0] pix, input logic start,
                                        output awp_result_t res);
        logic [1:0][2:0] rc;
        logic [1:0][2:0] cc;
        logic [1:0][1:0] rw;
        logic [1:0][1:0] cw;
        logic [2:0]      dr;
        logic [2:0]      dc;
        logic [3:0]      idx;
        logic [31:0]     scaled;
        int              nr;
        int              nc;
        bit              hit;
        res = '0;
        hit = 1'b0;
        if (start)
        begin
            next_row = '0;
            next_col = '0;
            for (int k = 0; k < LANES; k++)
                band_sum[k] = '0;
        end
        nr = axis_split(next_row, rc, rw);
        nc = axis_split(next_col, cc, cw);
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
            begin
                idx = {rc[i][0], cc[j]};
                band_sum[idx] = band_sum[idx] + 20'(pix) * 20'(rw[i]) * 20'(cw[j]);
            end
        if (axis_done(next_row, dr) && axis_done(next_col, dc))
        begin
            idx = {dr[0], dc};
            scaled = ((32'(band_sum[idx]) << DEF_FRACTION_BITS) + (CELL_WEIGHT / 2))
                     / CELL_WEIGHT;
            res.average = scaled[AVG_W-1:0];
            res.row = dr;
            res.col = dc;
            res.last = (dr == GRID_LAST) && (dc == GRID_LAST);
            band_sum[idx] = '0;
            hit = 1'b1;
        end
        if (next_col == IMG_SIDE - 1)
        begin
            next_col = '0;
            next_row = (next_row == IMG_SIDE - 1) ? 5'd0 : next_row + 5'd1;
        end
        else
            next_col = next_col + 5'd1;
        return hit;
    endfunction

    task automatic add_run(input int len, input bit marker, input fill_t fill);
        pixel_word_t w;
        for (int k = 0; k < len; k++)
        begin
            case (fill)
                FILL_MAX:     w.pixel = '1;
                FILL_ZERO:    w.pixel = '0;
                FILL_EXTREME:
                    case ($urandom_range(0, 2))
                        0:       w.pixel = '0;
                        1:       w.pixel = '1;
                        default: w.pixel = PIXEL_W'($urandom);
                    endcase
                default:      w.pixel = PIXEL_W'($urandom);
            endcase
            w.start = marker && (k == 0);
            pixel_words.push_back(w);
            total_words++;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endtask

    // pixel word driver
    always @(posedge clk)
    begin
        pixel_word_t w;
        if (!rst_n)
            push <= 1'b0;
        else if (!push || !full)
        begin
            if (send_idle > 0)
            begin
                send_idle--;
                push <= 1'b0;
            end
            else if (pixel_words.size() == 0)
                push <= 1'b0;
            else if (pixel_words.size() > TAIL_WORDS && $urandom_range(0, 15) == 0)
            begin
                send_idle = $urandom_range(0, 17);
                push <= 1'b0;
            end
            else
            begin
                w = pixel_words.pop_front();
                push <= 1'b1;
                pixel <= w.pixel;
                frame_start <= w.start;
            end
        end
    end

    // prediction on accepted pixels, checking and pop on cell words
    always @(posedge clk)
    begin
        awp_result_t fresh;
        awp_result_t oldest;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                accepted_words++;
                if (predict_cell(pixel, frame_start, fresh))
                    cell_words.push_back(fresh);
            end
            if (pop && !empty)
            begin
                if (cell_words.size() == 0)
                begin
                    $error("unexpected cell word: average %0d row %0d col %0d last %0d",
                           average, out_row, out_col, frame_last);
                    errors++;
                end
                else
                begin
                    oldest = cell_words.pop_front();
                    check_field("average", int'(oldest.average), int'(average));
                    check_field("out_row", int'(oldest.row), int'(out_row));
                    check_field("out_col", int'(oldest.col), int'(out_col));
                    check_field("frame_last", int'(oldest.last), int'(frame_last));
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle--;
                pop <= 1'b0;
            end
            else if (pixel_words.size() > TAIL_WORDS && $urandom_range(0, 15) == 0)
            begin
                recv_idle = $urandom_range(0, 17);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        int seg;
        int rand_words;
        int len;
        bit marker;
        fill_t fill;
        next_row = '0;
        next_col = '0;
        for (int k = 0; k < LANES; k++)
            band_sum[k] = '0;

        // directed: extremes, restart inside an image, back-to-back markers
        add_run(8, 1'b1, FILL_MAX);
        add_run(6, 1'b0, FILL_ZERO);
        add_run(1, 1'b1, FILL_ZERO);
        add_run(1, 1'b1, FILL_MAX);
        add_run(9, 1'b0, FILL_RANDOM);

        // random: broken image, full bright image, wrap with no marker, dark start, mixed runs
        seg = 0;
        rand_words = 0;
        while (seg < 4 || rand_words < 1000)
        begin
            case (seg)
                0:
                begin
                    len = $urandom_range(1, 100);
                    marker = 1'b1;
                    fill = FILL_EXTREME;
                end
                1:
                begin
                    len = IMG_PIXELS;
                    marker = 1'b1;
                    fill = FILL_MAX;
                end
                2:
                begin
                    len = $urandom_range(40, 120);
                    marker = 1'b0;
                    fill = FILL_RANDOM;
                end
                3:
                begin
                    len = $urandom_range(40, 120);
                    marker = 1'b1;
                    fill = FILL_ZERO;
                end
                default:
                begin
                    len = $urandom_range(1, 1000 - rand_words);
                    marker = ($urandom_range(0, 4) != 0);
                    fill = fill_t'($urandom_range(0, 3));
                end
            endcase
            add_run(len, marker, fill);
            rand_words += len;
            seg++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_words < total_words)
            @(posedge clk);
        while (cell_words.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/awp_pkg.sv
src/awp_fifo.sv
src/awp_div49.sv
src/awp_front.sv
src/awp_back.sv
src/area_weighted_pool_28_to_8.sv
src/awp_checker.sv
tb/area_weighted_pool_28_to_8_test.sv
